// ===== sv/wpc_pkg.sv =====
// Shared constants, codes and types of the EEPROM write-back page cache.
package wpc_pkg;

    localparam int STORE_BYTES      = 1024;
    localparam int PAGE_BYTES       = 16;
    localparam int TWO_BYTE_ADDRESS = 1;

    localparam int PAGE_COUNT  = (STORE_BYTES + PAGE_BYTES - 1) / PAGE_BYTES;
    localparam int STORE_AW    = $clog2(STORE_BYTES);
    localparam int PAGE_W      = $clog2(PAGE_COUNT);
    localparam int BEAT_W      = $clog2(PAGE_BYTES + 1);
    localparam int SCAN_LANES  = 8;
    localparam int SCAN_GROUPS = (PAGE_COUNT + SCAN_LANES - 1) / SCAN_LANES;
    localparam int GROUP_W     = (SCAN_GROUPS > 1) ? $clog2(SCAN_GROUPS) : 1;
    localparam int LANE_W      = $clog2(SCAN_LANES);
    localparam int FRAME_AW    = 16;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    localparam logic [2:0] MODE_READ  = 3'd0;
    localparam logic [2:0] MODE_WRITE = 3'd1;
    localparam logic [2:0] MODE_FILL  = 3'd2;
    localparam logic [2:0] MODE_SET   = 3'd3;
    localparam logic [2:0] MODE_INC   = 3'd4;
    localparam logic [2:0] MODE_SYNC  = 3'd5;
    localparam logic [2:0] MODE_CLEAR = 3'd6;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_ADDR   = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    typedef struct packed {
        logic              set_en;
        logic [PAGE_W-1:0] set_page;
        logic              clr_en;
        logic [PAGE_W-1:0] clr_page;
        logic              clr_all;
    } dirty_ctl_t;

endpackage

// ===== sv/eeprom_writeback_page_cache_unit.sv =====
// Top level of the EEPROM write-back page cache: command sequencer and frame walker.
//
// A byte store of 1024 bytes shadows an EEPROM, with one dirty bit per 16-byte
// page and a 10-bit address pointer. Drive a command on mode/address/write_data/
// queue_accepted and pulse start while busy is low; the item is taken at that
// edge. Results come out one per cycle with out_valid high for exactly one
// cycle each; there is no way to hold them off, so the receiver must take every
// result as it appears. The last result of an item carries last. Read, write,
// fill, pointer and clear-dirty commands do their memory access and state
// update in the accept cycle and give their single result from the response
// state. A sync first scans the dirty map 8 pages per cycle, then, when the
// queue accepts, emits the frame at one byte per cycle: two address bytes,
// high first, then the 16 page bytes, 18 results in all, paced by the single
// read port of the store. A refused sync or a sync with nothing dirty gives
// one result after the scan. After reset the block holds busy high while it
// writes 0xFF into every byte of the store.
module eeprom_writeback_page_cache_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        queue_accepted,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic [1:0]  out_kind,
    output logic [9:0]  pointer_value,
    output logic        any_dirty,
    output logic        synced,
    output logic [5:0]  page_index,
    output logic        last
);
    import wpc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;  // erase pass after reset
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RESP  = 3'd2;  // single result
    localparam logic [2:0] ST_SCAN  = 3'd3;  // dirty map search
    localparam logic [2:0] ST_HI    = 3'd4;  // frame address high byte
    localparam logic [2:0] ST_LO    = 3'd5;  // frame address low byte
    localparam logic [2:0] ST_DATA  = 3'd6;  // frame data bytes

    logic [2:0]          state_reg, state_next;
    logic [STORE_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [9:0]          pointer_reg, pointer_next;
    logic [2:0]          mode_reg, mode_next;
    logic                accepted_reg, accepted_next;
    logic [1:0]          resp_kind_reg, resp_kind_next;
    logic [5:0]          resp_page_reg, resp_page_next;
    logic [GROUP_W-1:0]  group_reg, group_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [STORE_AW-1:0] ea_reg, ea_next;     // address of the data byte on the output
    logic [BEAT_W-1:0]   beat_reg, beat_next;

    logic                take;
    logic [STORE_AW-1:0] cmd_idx;
    logic [PAGE_W-1:0]   found_page;
    logic [FRAME_AW-1:0] page_base;
    logic                data_last;

    logic                ram_we, ram_re;
    logic [STORE_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]          ram_wdata, ram_rdata;

    dirty_ctl_t          dctl;
    logic                group_hit;
    logic [LANE_W-1:0]   group_lane;

    assign busy       = (state_reg != ST_IDLE);
    assign take       = start && !busy;
    assign cmd_idx    = STORE_AW'(address % 16'(STORE_BYTES));
    assign found_page = PAGE_W'({group_reg, group_lane});
    assign page_base  = FRAME_AW'(page_reg) * FRAME_AW'(PAGE_BYTES);
    assign data_last  = (beat_reg == BEAT_W'(PAGE_BYTES - 1))
                     || (ea_reg == STORE_AW'(STORE_BYTES - 1));

    wpc_byte_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    wpc_dirty_map u_dirty (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (dctl),
        .scan_group (group_reg),
        .group_hit  (group_hit),
        .group_lane (group_lane),
        .any_dirty  (any_dirty)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pointer_next   = pointer_reg;
        mode_next      = mode_reg;
        accepted_next  = accepted_reg;
        resp_kind_next = resp_kind_reg;
        resp_page_next = resp_page_reg;
        group_next     = group_reg;
        page_next      = page_reg;
        ea_next        = ea_reg;
        beat_next      = beat_reg;

        ram_we    = 1'b0;
        ram_waddr = cmd_idx;
        ram_wdata = write_data;
        ram_re    = 1'b0;
        ram_raddr = cmd_idx;

        dctl          = '0;
        dctl.set_page = PAGE_W'(cmd_idx / STORE_AW'(PAGE_BYTES));
        dctl.clr_page = found_page;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = ERASED_BYTE;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == STORE_AW'(STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    mode_next      = mode;
                    accepted_next  = queue_accepted;
                    resp_kind_next = KIND_STATUS;
                    resp_page_next = '0;
                    group_next     = '0;
                    state_next     = ST_RESP;
                    unique case (mode)
                        MODE_READ:  ram_re = 1'b1;
                        MODE_WRITE:
                        begin
                            ram_we      = 1'b1;
                            dctl.set_en = 1'b1;
                        end
                        MODE_FILL:  ram_we = 1'b1;
                        MODE_SET:   pointer_next = 10'(cmd_idx);
                        MODE_INC:
                        begin
                            if (pointer_reg == 10'(STORE_BYTES - 1))
                            begin
                                pointer_next = '0;
                            end
                            else
                            begin
                                pointer_next = pointer_reg + 1'b1;
                            end
                        end
                        MODE_SYNC:  state_next = ST_SCAN;
                        MODE_CLEAR: dctl.clr_all = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (group_hit)
                begin
                    page_next = found_page;
                    if (accepted_reg)
                    begin
                        dctl.clr_en = 1'b1;
                        state_next  = (TWO_BYTE_ADDRESS != 0) ? ST_HI : ST_LO;
                    end
                    else
                    begin
                        resp_kind_next = KIND_STATUS;
                        resp_page_next = 6'(found_page);
                        state_next     = ST_RESP;
                    end
                end
                else if (group_reg == GROUP_W'(SCAN_GROUPS - 1))
                begin
                    resp_kind_next = KIND_EMPTY;
                    resp_page_next = '0;
                    state_next     = ST_RESP;
                end
                else
                begin
                    group_next = group_reg + 1'b1;
                end
            end
            ST_HI:
            begin
                state_next = ST_LO;
            end
            ST_LO:
            begin
                // fetch the first page byte while the low address byte goes out
                ram_re     = 1'b1;
                ram_raddr  = STORE_AW'(page_base);
                ea_next    = STORE_AW'(page_base);
                beat_next  = '0;
                state_next = ST_DATA;
            end
            ST_DATA:
            begin
                if (data_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ea_reg + 1'b1;
                    ea_next   = ea_reg + 1'b1;
                    beat_next = beat_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            pointer_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            pointer_reg <= pointer_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        accepted_reg  <= accepted_next;
        resp_kind_reg <= resp_kind_next;
        resp_page_reg <= resp_page_next;
        group_reg     <= group_next;
        page_reg      <= page_next;
        ea_reg        <= ea_next;
        beat_reg      <= beat_next;
    end

    // result ports
    always_comb
    begin
        out_valid  = 1'b0;
        out_byte   = '0;
        out_kind   = KIND_STATUS;
        synced     = 1'b0;
        page_index = '0;
        last       = 1'b0;
        unique case (state_reg)
            ST_RESP:
            begin
                out_valid  = 1'b1;
                out_byte   = (mode_reg == MODE_READ) ? ram_rdata : 8'h00;
                out_kind   = resp_kind_reg;
                page_index = resp_page_reg;
                last       = 1'b1;
            end
            ST_HI:
            begin
                out_valid  = 1'b1;
                out_byte   = page_base[15:8];
                out_kind   = KIND_ADDR;
                synced     = 1'b1;
                page_index = 6'(page_reg);
            end
            ST_LO:
            begin
                out_valid  = 1'b1;
                out_byte   = page_base[7:0];
                out_kind   = KIND_ADDR;
                synced     = 1'b1;
                page_index = 6'(page_reg);
            end
            ST_DATA:
            begin
                out_valid  = 1'b1;
                out_byte   = ram_rdata;
                out_kind   = KIND_DATA;
                synced     = 1'b1;
                page_index = 6'(page_reg);
                last       = data_last;
            end
            default: ;
        endcase
    end

    assign pointer_value = pointer_reg;

    // an accepted item always makes the block busy in the cycle after it is taken
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> busy)
        else $error("item accepted but block not busy");

    // frame bytes are only address or data bytes
    a_sync_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && synced) |-> (out_kind == KIND_ADDR || out_kind == KIND_DATA))
        else $error("synced result with wrong kind");

    // an address byte is never the end of a frame
    a_addr_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind == KIND_ADDR) |-> !last)
        else $error("frame ended on an address byte");

    // after the last result the block is ready again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |=> !busy)
        else $error("block still busy after last result");

endmodule

// ===== sv/wpc_byte_ram.sv =====
// Byte store memory: one write port, one read port with registered data.
module wpc_byte_ram (
    input  logic                         clk,
    input  logic                         we,
    input  logic [wpc_pkg::STORE_AW-1:0] waddr,
    input  logic [7:0]                   wdata,
    input  logic                         re,
    input  logic [wpc_pkg::STORE_AW-1:0] raddr,
    output logic [7:0]                   rdata
);
    import wpc_pkg::*;

    logic [7:0] mem [STORE_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/wpc_dirty_map.sv =====
// Dirty page bitmap with a one-group-per-cycle lowest-set-bit scan lane.
module wpc_dirty_map (
    input  logic                        clk,
    input  logic                        rst_n,
    input  wpc_pkg::dirty_ctl_t         ctl,
    input  logic [wpc_pkg::GROUP_W-1:0] scan_group,
    output logic                        group_hit,
    output logic [wpc_pkg::LANE_W-1:0]  group_lane,
    output logic                        any_dirty
);
    import wpc_pkg::*;

    localparam int MAP_BITS = SCAN_GROUPS * SCAN_LANES;

    logic [MAP_BITS-1:0]   dirty_reg;
    logic [MAP_BITS-1:0]   dirty_next;
    logic [SCAN_LANES-1:0] group_bits;

    always_comb
    begin
        dirty_next = dirty_reg;
        if (ctl.clr_all)
        begin
            dirty_next = '0;
        end
        if (ctl.set_en)
        begin
            dirty_next[ctl.set_page] = 1'b1;
        end
        if (ctl.clr_en)
        begin
            dirty_next[ctl.clr_page] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= '0;
        end
        else
        begin
            dirty_reg <= dirty_next;
        end
    end

    // lowest set bit of the selected group
    always_comb
    begin
        group_bits = dirty_reg[scan_group*SCAN_LANES +: SCAN_LANES];
        group_hit  = |group_bits;
        group_lane = '0;
        for (int i = SCAN_LANES - 1; i >= 0; i--)
        begin
            if (group_bits[i])
            begin
                group_lane = LANE_W'(i);
            end
        end
    end

    assign any_dirty = |dirty_reg;

endmodule
